// ===== rtl/gbk_pkg.sv =====
// Shared request types, constants and controller/datapath interface structs.
`timescale 1ns / 1ps
`default_nettype none

package gbk_pkg;

    localparam int VALUE_W = 32;
    localparam int KEY_W   = VALUE_W + 1;
    localparam int LINE_W  = 7;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      end_marker;
    } t_in_req;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [LINE_W-1:0]       seq_no;
        logic                    group_last;
        logic                    batch_last;
    } t_out_req;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_value;
        logic search_step;
        logic new_grp;
        logic join_rd;
        logic join_wr;
        logic emit_start;
        logic load_grp;
        logic out_load;
        logic grp_next;
        logic follow;
        logic clear;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic items_empty;
        logic grp_empty;
        logic full;
        logic hit;
        logic miss;
        logic out_free;
        logic group_last;
        logic batch_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/gbk_controller.sv =====
// Sequencer for key search, group insertion and grouped emission.
`timescale 1ns / 1ps
`default_nettype none

module gbk_controller (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_end_marker,
    output logic               o_in_ready,
    input  wire gbk_pkg::t_sts i_sts,
    output gbk_pkg::t_cmd      o_cmd
);
    import gbk_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SEARCH  = 4'd1;
    localparam logic [3:0] S_NEW     = 4'd2;
    localparam logic [3:0] S_JOIN_RD = 4'd3;
    localparam logic [3:0] S_JOIN_WR = 4'd4;
    localparam logic [3:0] S_E_GRP   = 4'd5;
    localparam logic [3:0] S_E_LOAD  = 4'd6;
    localparam logic [3:0] S_E_OUT   = 4'd7;
    localparam logic [3:0] S_E_NEXT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_end_marker) begin
                        if (!i_sts.items_empty) begin
                            o_cmd.emit_start = 1'b1;
                            n_state          = S_E_GRP;
                        end
                    end else if (!i_sts.full) begin
                        o_cmd.accept_value = 1'b1;
                        n_state            = i_sts.grp_empty ? S_NEW : S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_JOIN_RD;
                end else if (i_sts.miss) begin
                    n_state = S_NEW;
                end
            end
            S_NEW: begin
                o_cmd.new_grp = 1'b1;
                n_state       = S_IDLE;
            end
            S_JOIN_RD: begin
                o_cmd.join_rd = 1'b1;
                n_state       = S_JOIN_WR;
            end
            S_JOIN_WR: begin
                o_cmd.join_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_E_GRP: begin
                n_state = S_E_LOAD;
            end
            S_E_LOAD: begin
                o_cmd.load_grp = 1'b1;
                n_state        = S_E_OUT;
            end
            S_E_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.batch_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else if (i_sts.group_last) begin
                        o_cmd.grp_next = 1'b1;
                        n_state        = S_E_GRP;
                    end else begin
                        n_state = S_E_NEXT;
                    end
                end
            end
            S_E_NEXT: begin
                o_cmd.follow = 1'b1;
                n_state      = S_E_OUT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/gbk_datapath.sv =====
// Key and list memories, counters, search compare and output register.
`timescale 1ns / 1ps
`default_nettype none

module gbk_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gbk_pkg::t_in_req  i_in_data,
    input  wire gbk_pkg::t_cmd     i_cmd,
    output gbk_pkg::t_sts          o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output gbk_pkg::t_out_req      o_out_data
);
    import gbk_pkg::*;

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic [IDX_W-1:0] head;
        logic [IDX_W-1:0] tail;
    } t_ht;

    // Group key store, per-group list head/tail, per-item next link.
    logic [KEY_W-1:0] r_key_mem  [MAX_ITEMS];
    t_ht              r_ht_mem   [MAX_ITEMS];
    logic [IDX_W-1:0] r_next_mem [MAX_ITEMS];

    logic [KEY_W-1:0] r_key_rd;
    t_ht              r_ht_rd;
    logic [IDX_W-1:0] r_next_rd;

    logic [CNT_W-1:0] r_item_cnt;
    logic [CNT_W-1:0] r_grp_cnt;
    logic [CNT_W-1:0] r_gidx;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [IDX_W-1:0] r_hit_grp;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_okey;
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] r_tail;
    logic             r_out_vld;
    t_out_req         r_out;

    logic             match;
    logic             more;
    logic [IDX_W-1:0] item_idx;
    logic [IDX_W-1:0] ht_ra;
    logic             ht_we;
    logic [IDX_W-1:0] ht_wa;
    t_ht              ht_wd;
    t_out_req         out_nxt;

    assign item_idx = r_item_cnt[IDX_W-1:0];
    assign more     = (r_gidx < r_grp_cnt);
    assign match    = r_cmp_vld && (r_key_rd == r_key);
    assign ht_ra    = i_cmd.join_rd ? r_hit_grp : r_gidx[IDX_W-1:0];
    assign ht_we    = i_cmd.new_grp || i_cmd.join_wr;
    assign ht_wa    = i_cmd.new_grp ? r_grp_cnt[IDX_W-1:0] : r_hit_grp;

    always_comb begin
        ht_wd.tail = item_idx;
        ht_wd.head = i_cmd.new_grp ? item_idx : r_ht_rd.head;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.new_grp) begin
            r_key_mem[r_grp_cnt[IDX_W-1:0]] <= r_key;
        end
        if (ht_we) begin
            r_ht_mem[ht_wa] <= ht_wd;
        end
        if (i_cmd.join_wr) begin
            r_next_mem[r_ht_rd.tail] <= item_idx;
        end
        r_key_rd  <= r_key_mem[r_gidx[IDX_W-1:0]];
        r_ht_rd   <= r_ht_mem[ht_ra];
        r_next_rd <= r_next_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_cnt <= '0;
            r_grp_cnt  <= '0;
            r_gidx     <= '0;
            r_cmp_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_item_cnt <= '0;
                r_grp_cnt  <= '0;
            end else begin
                if (i_cmd.new_grp) begin
                    r_grp_cnt <= r_grp_cnt + CNT_W'(1);
                end
                if (i_cmd.new_grp || i_cmd.join_wr) begin
                    r_item_cnt <= r_item_cnt + CNT_W'(1);
                end
            end
            if (i_cmd.accept_value || i_cmd.emit_start) begin
                r_gidx <= '0;
            end else if ((i_cmd.search_step && more) || i_cmd.grp_next) begin
                r_gidx <= r_gidx + CNT_W'(1);
            end
            if (i_cmd.accept_value) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.search_step) begin
                r_cmp_vld <= more;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        out_nxt.key        = r_okey;
        out_nxt.seq_no     = LINE_W'(r_cur) + LINE_W'(1);
        out_nxt.group_last = o_sts.group_last;
        out_nxt.batch_last = o_sts.batch_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_value) begin
            r_key <= {i_in_data.value, 1'b0};
        end
        if (i_cmd.search_step) begin
            r_cmp_idx <= r_gidx[IDX_W-1:0];
        end
        if (i_cmd.search_step && match) begin
            r_hit_grp <= r_cmp_idx;
        end
        if (i_cmd.load_grp) begin
            r_okey <= r_key_rd;
            r_cur  <= r_ht_rd.head;
            r_tail <= r_ht_rd.tail;
        end else if (i_cmd.follow) begin
            r_cur <= r_next_rd;
        end
        if (i_cmd.out_load) begin
            r_out <= out_nxt;
        end
    end

    always_comb begin
        o_sts.items_empty = (r_item_cnt == '0);
        o_sts.grp_empty   = (r_grp_cnt == '0);
        o_sts.full        = (r_item_cnt == CNT_W'(MAX_ITEMS));
        o_sts.hit         = match;
        o_sts.miss        = r_cmp_vld && !match
                            && ((CNT_W'(r_cmp_idx) + CNT_W'(1)) == r_grp_cnt);
        o_sts.out_free    = !r_out_vld || i_out_ready;
        o_sts.group_last  = (r_cur == r_tail);
        o_sts.batch_last  = (r_cur == r_tail) && ((r_gidx + CNT_W'(1)) == r_grp_cnt);
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/group_by_key_collector.sv =====
// Top level of the group-by-key collector: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// The collector takes one signed 32-bit value per request, numbers the values 1, 2, 3 and so
// on in order of arrival, and doubles each one exactly into a 33-bit key. Keys are grouped in
// order of first appearance. A request with end_marker set ends the batch: the block then
// emits one result request per stored value, group by group in order of first appearance and,
// within a group, in ascending line number, with group_last on the final member of each
// group and batch_last on the very last result. The tables are then empty again. An end
// marker with no stored values produces nothing. Once MAX_ITEMS values are held, further
// values are accepted and dropped until the next end marker. Each value is compared against
// the stored group keys one per cycle through a single read port of the key memory. A value
// that opens a new group frees the input after it has been compared against every open group
// and then inserted (it is inserted at once when no group is open yet); a value that joins a
// group frees it after the compare reaches that group and the list tail is read and linked.
// Emission walks linked member lists kept per group: each group first loads its key, head and
// tail, then each member enters the output register and every member but the last of its
// group is followed by a read of the next link. An output stall holds the walk; otherwise
// the pace is set by the registered read of the link memory. The block takes the next
// request as soon as the last result has entered the output register, even while it waits.
// No clearing pass follows reset; the memories need none.

module group_by_key_collector #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire gbk_pkg::t_in_req  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output gbk_pkg::t_out_req      o_out_data
);
    import gbk_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencing: search, insert into a group list, then walk the lists on an end marker.
    gbk_controller u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_end_marker (i_in_data.end_marker),
        .o_in_ready   (o_in_ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // Storage, counters, key compare and the output register.
    gbk_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
